// ----- hw/rtl/gbfp_pkg.sv -----
// Shared constants and types for the binary frame parser.
`default_nettype none

package gbfp_pkg;

    localparam logic [7:0]  SYNC_FIRST  = 8'hB5;
    localparam logic [7:0]  SYNC_SECOND = 8'h62;
    localparam logic [7:0]  CLASS_NAV   = 8'h01;
    localparam logic [7:0]  CLASS_ACK   = 8'h05;
    localparam logic [7:0]  CLASS_CFG   = 8'h06;

    localparam logic [15:0] MAX_LEN_RESET = 16'd256;

    // Frame positions held in the byte position counter.
    localparam logic [15:0] POS_HUNT     = 16'd0;
    localparam logic [15:0] POS_SYNC2    = 16'd1;
    localparam logic [15:0] POS_CLASS    = 16'd2;
    localparam logic [15:0] POS_ID       = 16'd3;
    localparam logic [15:0] POS_LEN_LSB  = 16'd4;
    localparam logic [15:0] POS_LEN_MSB  = 16'd5;
    localparam logic [15:0] POS_PAYLOAD  = 16'd6;

    typedef struct packed {
        logic       valid;
        logic [7:0] data;
    } gbfp_stage_t;

    typedef struct packed {
        logic        payload_valid;
        logic [15:0] payload_index;
        logic [7:0]  payload_byte;
        logic        frame_good;
        logic [7:0]  frame_class;
        logic [7:0]  frame_id;
        logic [15:0] frame_length;
    } gbfp_result_t;

endpackage

`default_nettype wire

// ----- hw/rtl/gbfp_byte_if.sv -----
// Received byte channel with valid/ready handshake.
`default_nettype none

interface gbfp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/gbfp_result_if.sv -----
// Per-byte result channel with valid/ready handshake.
`default_nettype none

interface gbfp_result_if;
    logic        valid;
    logic        ready;
    logic        payload_valid;
    logic [15:0] payload_index;
    logic [7:0]  payload_byte;
    logic        frame_good;
    logic [7:0]  frame_class;
    logic [7:0]  frame_id;
    logic [15:0] frame_length;

    modport source (output valid, output payload_valid, output payload_index,
                    output payload_byte, output frame_good, output frame_class,
                    output frame_id, output frame_length, input ready);
    modport sink   (input valid, input payload_valid, input payload_index,
                    input payload_byte, input frame_good, input frame_class,
                    input frame_id, input frame_length, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/gbfp_in_stage.sv -----
// Input register that holds one received byte until the parser takes it.
`default_nettype none

module gbfp_in_stage
    import gbfp_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        rx_valid,
    input  wire logic [7:0]  rx_data,
    output logic             rx_ready,
    input  wire logic        take,
    output gbfp_stage_t      stage
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] data_reg;

    // The register is free when empty or when its byte leaves this cycle.
    assign rx_ready   = !valid_reg || take;
    assign valid_next = rx_ready ? rx_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx_valid && rx_ready)
        begin
            data_reg <= rx_data;
        end
    end

    assign stage.valid = valid_reg;
    assign stage.data  = data_reg;

    a_take_needs_byte: assert property (@(posedge clk) disable iff (!rst_n)
        take |-> valid_reg)
        else $error("parser took a byte from an empty input register");

    a_held_byte_kept: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && !take |=> valid_reg && data_reg == $past(data_reg))
        else $error("unconsumed input byte was lost or overwritten");

    a_rx_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !valid_reg |-> rx_ready)
        else $error("empty input register refused a transfer");

endmodule

`default_nettype wire

// ----- hw/rtl/gbfp_core.sv -----
// Frame tracking state, Fletcher sums and the result register.
`default_nettype none

module gbfp_core
    import gbfp_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         cfg_wr_en,
    input  wire logic [15:0]  cfg_wr_data,
    input  wire gbfp_stage_t  stage,
    output logic              take,
    output logic              res_valid,
    input  wire logic         res_ready,
    output gbfp_result_t      res
);

    logic [15:0]  max_len_reg;
    logic [15:0]  pos_reg;
    logic [15:0]  pos_next;
    logic [7:0]   sum_a_reg;
    logic [7:0]   sum_a_next;
    logic [7:0]   sum_b_reg;
    logic [7:0]   sum_b_next;
    logic [7:0]   class_reg;
    logic [7:0]   class_next;
    logic [7:0]   id_reg;
    logic [7:0]   id_next;
    logic [15:0]  len_reg;
    logic [15:0]  len_next;
    logic         res_valid_reg;
    logic         res_valid_next;
    gbfp_result_t res_reg;
    gbfp_result_t res_next;

    logic [7:0]   c;
    logic [16:0]  pos_wide;
    logic [16:0]  end_wide;
    logic [7:0]   acc_a;
    logic [7:0]   acc_b;
    logic [15:0]  len_full;
    logic [15:0]  pos_inc;
    logic         step_valid;
    logic [15:0]  step_index;
    logic         step_good;

    assign take           = stage.valid && (!res_valid_reg || res_ready);
    assign res_valid_next = take || (res_valid_reg && !res_ready);

    assign c        = stage.data;
    assign pos_wide = {1'b0, pos_reg};
    // The end of the payload is compared at 17 bits so that it cannot wrap.
    assign end_wide = {1'b0, len_reg} + 17'(POS_PAYLOAD);
    assign acc_a    = sum_a_reg + c;
    assign acc_b    = sum_b_reg + acc_a;
    assign len_full = {c, len_reg[7:0]};
    assign pos_inc  = pos_reg + 16'd1;

    always_comb
    begin
        pos_next   = pos_reg;
        sum_a_next = sum_a_reg;
        sum_b_next = sum_b_reg;
        class_next = class_reg;
        id_next    = id_reg;
        len_next   = len_reg;
        step_valid = 1'b0;
        step_index = 16'd0;
        step_good  = 1'b0;

        if (pos_reg == POS_HUNT || (pos_reg == POS_SYNC2 && c == SYNC_FIRST))
        begin
            pos_next   = (c == SYNC_FIRST) ? POS_SYNC2 : POS_HUNT;
            sum_a_next = 8'd0;
            sum_b_next = 8'd0;
        end
        else if (pos_reg == POS_SYNC2)
        begin
            pos_next = (c == SYNC_SECOND) ? POS_CLASS : POS_HUNT;
        end
        else if (pos_reg == POS_CLASS)
        begin
            if (c == CLASS_NAV || c == CLASS_ACK || c == CLASS_CFG)
            begin
                class_next = c;
                pos_next   = POS_ID;
                sum_a_next = acc_a;
                sum_b_next = acc_b;
            end
            else
            begin
                pos_next = POS_HUNT;
            end
        end
        else if (pos_reg == POS_ID)
        begin
            id_next    = c;
            pos_next   = POS_LEN_LSB;
            sum_a_next = acc_a;
            sum_b_next = acc_b;
        end
        else if (pos_reg == POS_LEN_LSB)
        begin
            len_next   = {8'd0, c};
            pos_next   = POS_LEN_MSB;
            sum_a_next = acc_a;
            sum_b_next = acc_b;
        end
        else if (pos_reg == POS_LEN_MSB)
        begin
            len_next = len_full;
            if (len_full > max_len_reg)
            begin
                pos_next = POS_HUNT;
            end
            else
            begin
                pos_next   = POS_PAYLOAD;
                sum_a_next = acc_a;
                sum_b_next = acc_b;
            end
        end
        else if (pos_wide < end_wide)
        begin
            step_valid = 1'b1;
            step_index = pos_reg - POS_PAYLOAD;
            pos_next   = pos_inc;
            sum_a_next = acc_a;
            sum_b_next = acc_b;
        end
        else if (pos_wide == end_wide)
        begin
            pos_next = (sum_a_reg == c) ? pos_inc : POS_HUNT;
        end
        else
        begin
            pos_next  = POS_HUNT;
            step_good = (sum_b_reg == c);
        end
    end

    always_comb
    begin
        res_next.payload_valid = step_valid;
        res_next.payload_index = step_index;
        res_next.payload_byte  = step_valid ? c : 8'd0;
        res_next.frame_good    = step_good;
        res_next.frame_class   = class_next;
        res_next.frame_id      = id_next;
        res_next.frame_length  = len_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_len_reg   <= MAX_LEN_RESET;
            pos_reg       <= POS_HUNT;
            sum_a_reg     <= 8'd0;
            sum_b_reg     <= 8'd0;
            class_reg     <= 8'd0;
            id_reg        <= 8'd0;
            len_reg       <= 16'd0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                max_len_reg <= cfg_wr_data;
            end
            if (take)
            begin
                pos_reg   <= pos_next;
                sum_a_reg <= sum_a_next;
                sum_b_reg <= sum_b_next;
                class_reg <= class_next;
                id_reg    <= id_next;
                len_reg   <= len_next;
            end
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            res_reg <= res_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    a_sums_clear_after_sync: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg == POS_SYNC2 |-> sum_a_reg == 8'd0 && sum_b_reg == 8'd0)
        else $error("Fletcher sums not cleared while waiting for second sync");

    a_good_returns_to_hunt: assert property (@(posedge clk) disable iff (!rst_n)
        take && step_good |=> pos_reg == POS_HUNT)
        else $error("parser did not return to the hunt after a good frame");

    a_payload_advances: assert property (@(posedge clk) disable iff (!rst_n)
        take && step_valid |=> pos_reg == $past(pos_reg) + 16'd1)
        else $error("payload byte did not advance the byte position");

    a_payload_not_good: assert property (@(posedge clk) disable iff (!rst_n)
        take |=> !(res_reg.payload_valid && res_reg.frame_good))
        else $error("one result flagged both a payload byte and a good frame");

endmodule

`default_nettype wire

// ----- hw/rtl/gbfp_top_note.sv -----
// Result-channel driver between the parser core and the result port.
`default_nettype none

module gbfp_res_drive
    import gbfp_pkg::*;
(
    input  wire logic     res_valid,
    input  wire gbfp_result_t res,
    output logic          res_ready,
    gbfp_result_if.source result
);

    // Unpacks the registered result word onto the channel fields.
    assign result.valid         = res_valid;
    assign result.payload_valid = res.payload_valid;
    assign result.payload_index = res.payload_index;
    assign result.payload_byte  = res.payload_byte;
    assign result.frame_good    = res.frame_good;
    assign result.frame_class   = res.frame_class;
    assign result.frame_id      = res.frame_id;
    assign result.frame_length  = res.frame_length;
    assign res_ready            = result.ready;

endmodule

`default_nettype wire

// ----- hw/rtl/gnss_binary_frame_parser.sv -----
// Top level of the framed binary message parser.
//
// Received bytes arrive one per transfer on rx_chan. Every byte yields exactly one
// transfer on result: payload bytes are flagged with their index within the payload,
// and the second checksum byte of a frame with matching Fletcher sums raises
// frame_good. Only classes 0x01, 0x05 and 0x06 are followed; other frames, bad sync,
// over-long lengths and bad checksums send the parser quietly back to the hunt for 0xB5 0x62.
// The user buffers payload bytes and commits them when frame_good is seen.
// cfg_wr_en/cfg_wr_data set the largest accepted payload length (256 after reset);
// write it only while no bytes are in flight.
// A byte taken into the input register is loaded into the result register when the core
// takes it and is offered on result from then on. Throughput: one byte every cycle while
// result is not stalled, set by the combinational state update between the two registers.
// Reset clears both valid flags and the frame state, so the parser starts hunting.
// When the receiver stalls, the result register holds its item and the input
// register absorbs one further byte; rx_chan.ready then drops until result moves.
`default_nettype none

module gnss_binary_frame_parser
    import gbfp_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         cfg_wr_en,
    input  wire logic [15:0]  cfg_wr_data,
    gbfp_byte_if.sink         rx_chan,
    gbfp_result_if.source     result
);

    gbfp_stage_t  stage;
    gbfp_result_t res;
    logic         take;
    logic         rx_ready;
    logic         res_valid;
    logic         res_ready;

    assign rx_chan.ready = rx_ready;

    gbfp_in_stage u_in_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .rx_valid (rx_chan.valid),
        .rx_data  (rx_chan.rx_byte),
        .rx_ready (rx_ready),
        .take     (take),
        .stage    (stage)
    );

    gbfp_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .stage       (stage),
        .take        (take),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res)
    );

    gbfp_res_drive u_res_drive (
        .res_valid (res_valid),
        .res       (res),
        .res_ready (res_ready),
        .result    (result)
    );

endmodule

`default_nettype wire
